>>> rtl/core/tmc_pkg.sv
// Shared constants and types for the touch median and calibration block.
// Holds register indexes, threshold and mapping constants, and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmc_pkg;

	localparam int CAL_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int ORIENT_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_VALID    = 3'd0,
		REG_RAW_MODE     = 3'd1,
		REG_ORIENT_FLAGS = 3'd2,
		REG_CAL_MIN_X    = 3'd3,
		REG_CAL_MAX_X    = 3'd4,
		REG_CAL_MIN_Y    = 3'd5,
		REG_CAL_MAX_Y    = 3'd6
	} cfg_reg_t;

	localparam int PRESS_MIN = 80;
	localparam int EDGE_LOW  = 80;
	localparam int EDGE_HIGH = 4015;
	localparam int PROV_LO   = 200;
	localparam int PROV_HI   = 3900;

	localparam int ORIENT_SWAP  = 0;
	localparam int ORIENT_INV_X = 1;
	localparam int ORIENT_INV_Y = 2;

	localparam logic [CAL_W-1:0] RST_CAL_MIN = CAL_W'(PROV_LO);
	localparam logic [CAL_W-1:0] RST_CAL_MAX = CAL_W'(PROV_HI);

endpackage

`default_nettype wire

>>> rtl/core/tmc_if.sv
// Channel interfaces of the touch median and calibration block: reading sets in,
// results out, and the configuration write channel. Depends on tmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tmc_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] first_x;
	logic [SAMPLE_BITS-1:0] first_y;
	logic [SAMPLE_BITS-1:0] first_z;
	logic [SAMPLE_BITS-1:0] second_x;
	logic [SAMPLE_BITS-1:0] second_y;
	logic [SAMPLE_BITS-1:0] second_z;
	logic [SAMPLE_BITS-1:0] third_x;
	logic [SAMPLE_BITS-1:0] third_y;
	logic [SAMPLE_BITS-1:0] third_z;

	modport source (
		output valid, first_x, first_y, first_z, second_x, second_y, second_z,
			third_x, third_y, third_z,
		input ready
	);
	modport sink (
		input valid, first_x, first_y, first_z, second_x, second_y, second_z,
			third_x, third_y, third_z,
		output ready
	);
endinterface

interface tmc_out_if #(
	parameter int SAMPLE_BITS = 12,
	parameter int X_BITS = 8,
	parameter int Y_BITS = 9
);
	logic                   valid;
	logic                   ready;
	logic                   touch_valid;
	logic [SAMPLE_BITS-1:0] raw_x_med;
	logic [SAMPLE_BITS-1:0] raw_y_med;
	logic [X_BITS-1:0]      screen_x;
	logic [Y_BITS-1:0]      screen_y;

	modport source (
		output valid, touch_valid, raw_x_med, raw_y_med, screen_x, screen_y,
		input ready
	);
	modport sink (
		input valid, touch_valid, raw_x_med, raw_y_med, screen_x, screen_y,
		output ready
	);
endinterface

interface tmc_cfg_if import tmc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tmc_median3.sv
// Median of three samples for one axis of a reading set.
// Purely combinational; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tmc_median3 #(
	parameter int W = 12
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] c,
	output logic [W-1:0] med
);
	logic [W-1:0] lo_ab;
	logic [W-1:0] hi_ab;
	logic [W-1:0] lo_hc;

	assign lo_ab = (a < b) ? a : b;
	assign hi_ab = (a < b) ? b : a;
	assign lo_hc = (hi_ab < c) ? hi_ab : c;
	assign med   = (lo_ab > lo_hc) ? lo_ab : lo_hc;
endmodule

`default_nettype wire

>>> rtl/core/tmc_axis_lane.sv
// One axis of the linear screen mapping: offset, scale, pipelined restoring
// division one quotient bit per stage, then inversion and saturation. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tmc_axis_lane #(
	parameter int AW  = 12,
	parameter int PW  = 9,
	parameter int TOP = 239,
	parameter int OW  = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] pos,
	input  logic [AW-1:0] lo,
	input  logic [AW-1:0] hi,
	input  logic          inv,
	output logic [OW-1:0] coord
);
	localparam int NW = AW + PW;
	localparam int VW = NW + 2;
	localparam logic [PW-1:0]        TOP_P = PW'(TOP);
	localparam logic signed [VW-1:0] TOP_V = VW'(TOP);

	logic [AW:0]   diff;
	logic [AW:0]   span;
	logic [AW-1:0] dmag;
	logic [AW-1:0] smag;

	logic [AW-1:0] dmag_s1;
	logic [AW-1:0] smag_s1;
	logic          neg_s1;
	logic          zero_s1;
	logic          inv_s1;

	logic [NW-1:0] prod;

	logic [NW-1:0] num_q  [0:NW];
	logic [NW-1:0] quo_q  [0:NW];
	logic [AW-1:0] rem_q  [0:NW];
	logic [AW-1:0] den_q  [0:NW];
	logic          neg_q  [0:NW];
	logic          zero_q [0:NW];
	logic          inv_q  [0:NW];

	logic [AW:0]   trial [0:NW-1];
	logic          take  [0:NW-1];

	logic signed [VW-1:0] sval;
	logic signed [VW-1:0] ival;

	assign diff = {1'b0, pos} - {1'b0, lo};
	assign span = {1'b0, hi} - {1'b0, lo};
	assign dmag = diff[AW] ? AW'(-diff) : diff[AW-1:0];
	assign smag = span[AW] ? AW'(-span) : span[AW-1:0];
	assign prod = NW'(dmag_s1) * NW'(TOP_P);

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s1 <= dmag;
			smag_s1 <= smag;
			neg_s1  <= diff[AW] ^ span[AW];
			zero_s1 <= (span == '0);
			inv_s1  <= inv;
		end
	end

	always_comb begin
		for (int k = 0; k < NW; k++) begin
			trial[k] = {rem_q[k], num_q[k][NW-1]};
			take[k]  = (trial[k] >= {1'b0, den_q[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0]  <= prod;
			quo_q[0]  <= '0;
			rem_q[0]  <= '0;
			den_q[0]  <= smag_s1;
			neg_q[0]  <= neg_s1;
			zero_q[0] <= zero_s1;
			inv_q[0]  <= inv_s1;
			for (int k = 0; k < NW; k++) begin
				rem_q[k+1]  <= take[k] ? AW'(trial[k] - {1'b0, den_q[k]}) : trial[k][AW-1:0];
				num_q[k+1]  <= {num_q[k][NW-2:0], 1'b0};
				quo_q[k+1]  <= {quo_q[k][NW-2:0], take[k]};
				den_q[k+1]  <= den_q[k];
				neg_q[k+1]  <= neg_q[k];
				zero_q[k+1] <= zero_q[k];
				inv_q[k+1]  <= inv_q[k];
			end
		end
	end

	always_comb begin
		sval = $signed({2'b00, quo_q[NW]});
		if (neg_q[NW]) begin
			sval = -sval;
		end
		if (zero_q[NW]) begin
			sval = '0;
		end
		ival = inv_q[NW] ? (TOP_V - sval) : sval;
		if (ival < 0) begin
			coord = '0;
		end else if (ival > TOP_V) begin
			coord = OW'(TOP);
		end else begin
			coord = ival[OW-1:0];
		end
	end
endmodule

`default_nettype wire

>>> rtl/core/touch_median_calibrate_top.sv
// Top level of the touch median and calibration block: configuration registers,
// median and threshold stage, two axis lanes, and the output register with skid.
// Depends on tmc_pkg, tmc_if, tmc_median3 and tmc_axis_lane.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one reading set per clock while the skid register is empty, and
// returns exactly one result beat per reading set, in order. Each axis lane uses a
// restoring divider that resolves one quotient bit per stage.
// The output has a one-beat skid register, so input beats keep being taken while
// one finished result waits; the input stalls only once that skid register is full.
// Configuration writes are accepted every cycle and should only be issued while
// the block is empty.
module touch_median_calibrate_top import tmc_pkg::*; #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320,
	parameter int SAMPLE_BITS   = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	tmc_in_if.sink   samples,
	tmc_out_if.source result,
	tmc_cfg_if.sink  cfg
);
	localparam int S     = SAMPLE_BITS;
	localparam int AW    = (S > CAL_W) ? S : CAL_W;
	localparam int XW    = $clog2(SCREEN_WIDTH);
	localparam int YW    = $clog2(SCREEN_HEIGHT);
	localparam int PW    = (XW > YW) ? XW : YW;
	localparam int DEPTH = AW + PW + 2;

	typedef struct packed {
		logic         touch;
		logic [S-1:0] rx;
		logic [S-1:0] ry;
	} side_t;

	typedef struct packed {
		logic          touch_valid;
		logic [S-1:0]  raw_x_med;
		logic [S-1:0]  raw_y_med;
		logic [XW-1:0] screen_x;
		logic [YW-1:0] screen_y;
	} res_t;

	logic                cal_valid_q;
	logic                raw_mode_q;
	logic [ORIENT_W-1:0] orient_q;
	logic [CAL_W-1:0]    cal_min_x_q;
	logic [CAL_W-1:0]    cal_max_x_q;
	logic [CAL_W-1:0]    cal_min_y_q;
	logic [CAL_W-1:0]    cal_max_y_q;

	logic [S-1:0]  mx;
	logic [S-1:0]  my;
	logic [S-1:0]  mz;
	logic [AW-1:0] mx_w;
	logic [AW-1:0] my_w;
	logic [AW-1:0] mz_w;
	logic          pass;
	side_t         side_d;

	logic [AW-1:0] ax_d, lox_d, hix_d, ay_d, loy_d, hiy_d;
	logic          invx_d, invy_d;

	logic [AW-1:0] ax_s1, lox_s1, hix_s1, ay_s1, loy_s1, hiy_s1;
	logic          invx_s1, invy_s1;

	logic           en;
	logic           accept;
	logic [DEPTH:0] vld_q;
	side_t          side_q [0:DEPTH];

	logic [XW-1:0] cx;
	logic [YW-1:0] cy;

	res_t res_d;
	res_t out_q;
	res_t skid_q;
	logic out_v_q;
	logic skid_v_q;
	logic out_ld;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_valid_q <= 1'b0;
			raw_mode_q  <= 1'b1;
			orient_q    <= '0;
			cal_min_x_q <= RST_CAL_MIN;
			cal_max_x_q <= RST_CAL_MAX;
			cal_min_y_q <= RST_CAL_MIN;
			cal_max_y_q <= RST_CAL_MAX;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_CAL_VALID:    cal_valid_q <= cfg.data[0];
				REG_RAW_MODE:     raw_mode_q  <= cfg.data[0];
				REG_ORIENT_FLAGS: orient_q    <= cfg.data[ORIENT_W-1:0];
				REG_CAL_MIN_X:    cal_min_x_q <= cfg.data[CAL_W-1:0];
				REG_CAL_MAX_X:    cal_max_x_q <= cfg.data[CAL_W-1:0];
				REG_CAL_MIN_Y:    cal_min_y_q <= cfg.data[CAL_W-1:0];
				REG_CAL_MAX_Y:    cal_max_y_q <= cfg.data[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	tmc_median3 #(.W(S)) u_med_x (
		.a(samples.first_x), .b(samples.second_x), .c(samples.third_x), .med(mx)
	);
	tmc_median3 #(.W(S)) u_med_y (
		.a(samples.first_y), .b(samples.second_y), .c(samples.third_y), .med(my)
	);
	tmc_median3 #(.W(S)) u_med_z (
		.a(samples.first_z), .b(samples.second_z), .c(samples.third_z), .med(mz)
	);

	assign mx_w = AW'(mx);
	assign my_w = AW'(my);
	assign mz_w = AW'(mz);

	assign pass = (mz_w >= AW'(PRESS_MIN)) &&
		(mx_w >= AW'(EDGE_LOW)) && (mx_w <= AW'(EDGE_HIGH)) &&
		(my_w >= AW'(EDGE_LOW)) && (my_w <= AW'(EDGE_HIGH));

	always_comb begin
		side_d.touch = pass && (cal_valid_q || raw_mode_q);
		side_d.rx    = pass ? mx : '0;
		side_d.ry    = pass ? my : '0;
		if (cal_valid_q) begin
			ax_d   = orient_q[ORIENT_SWAP] ? my_w : mx_w;
			ay_d   = orient_q[ORIENT_SWAP] ? mx_w : my_w;
			lox_d  = AW'(cal_min_x_q);
			hix_d  = AW'(cal_max_x_q);
			loy_d  = AW'(cal_min_y_q);
			hiy_d  = AW'(cal_max_y_q);
			invx_d = orient_q[ORIENT_INV_X];
			invy_d = orient_q[ORIENT_INV_Y];
		end else begin
			ax_d   = mx_w;
			ay_d   = my_w;
			lox_d  = AW'(PROV_LO);
			hix_d  = AW'(PROV_HI);
			loy_d  = AW'(PROV_LO);
			hiy_d  = AW'(PROV_HI);
			invx_d = 1'b0;
			invy_d = 1'b0;
		end
	end

	assign en            = !skid_v_q;
	assign samples.ready = en;
	assign accept        = samples.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-1:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_d;
			for (int k = 1; k <= DEPTH; k++) begin
				side_q[k] <= side_q[k-1];
			end
			ax_s1   <= ax_d;
			lox_s1  <= lox_d;
			hix_s1  <= hix_d;
			invx_s1 <= invx_d;
			ay_s1   <= ay_d;
			loy_s1  <= loy_d;
			hiy_s1  <= hiy_d;
			invy_s1 <= invy_d;
		end
	end

	tmc_axis_lane #(.AW(AW), .PW(PW), .TOP(SCREEN_WIDTH - 1), .OW(XW)) u_lane_x (
		.clk(clk), .en(en), .pos(ax_s1), .lo(lox_s1), .hi(hix_s1), .inv(invx_s1),
		.coord(cx)
	);

	tmc_axis_lane #(.AW(AW), .PW(PW), .TOP(SCREEN_HEIGHT - 1), .OW(YW)) u_lane_y (
		.clk(clk), .en(en), .pos(ay_s1), .lo(loy_s1), .hi(hiy_s1), .inv(invy_s1),
		.coord(cy)
	);

	always_comb begin
		res_d.touch_valid = side_q[DEPTH].touch;
		res_d.raw_x_med   = side_q[DEPTH].rx;
		res_d.raw_y_med   = side_q[DEPTH].ry;
		res_d.screen_x    = side_q[DEPTH].touch ? cx : '0;
		res_d.screen_y    = side_q[DEPTH].touch ? cy : '0;
	end

	assign out_ld = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ld) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= vld_q[DEPTH];
			end
		end else if (vld_q[DEPTH] && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q <= skid_v_q ? skid_q : res_d;
		end else if (en) begin
			skid_q <= res_d;
		end
	end

	assign result.valid       = out_v_q;
	assign result.touch_valid = out_q.touch_valid;
	assign result.raw_x_med   = out_q.raw_x_med;
	assign result.raw_y_med   = out_q.raw_y_med;
	assign result.screen_x    = out_q.screen_x;
	assign result.screen_y    = out_q.screen_y;

	// The skid register only fills behind a stalled output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_idle_coord_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.touch_valid) |->
			(result.screen_x == '0 && result.screen_y == '0))
		else $error("screen position reported without a valid touch");

	a_touch_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.touch_valid) |->
			(AW'(result.raw_x_med) >= AW'(EDGE_LOW) && AW'(result.raw_x_med) <= AW'(EDGE_HIGH) &&
			AW'(result.raw_y_med) >= AW'(EDGE_LOW) && AW'(result.raw_y_med) <= AW'(EDGE_HIGH)))
		else $error("valid touch with a median outside the accepted window");

	a_coord_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			(result.screen_x <= XW'(SCREEN_WIDTH - 1) && result.screen_y <= YW'(SCREEN_HEIGHT - 1)))
		else $error("screen position beyond the panel size");
endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for touch_median_calibrate_top: directed table, then randomized phases
// under changing calibration, checked per beat against typed or predicted results.
// Depends on tmc_pkg, tmc_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import tmc_pkg::*;

	localparam int XTOP     = 239;
	localparam int YTOP     = 319;
	localparam int LATENCY  = 25;
	localparam int WATCHDOG = 1000;
	localparam int PHASES   = 8;
	localparam int PHASE_SETS = 50;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef enum int {SPAN_RESET, SPAN_FULL, SPAN_REVERSED, SPAN_RANDOM, SPAN_FLAT, SPAN_TYPICAL}
		span_kind_t;
	typedef enum int {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_t;

	typedef struct packed {
		logic [11:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
	} reading_t;

	typedef struct packed {
		logic       touch_valid;
		logic [11:0] raw_x_med;
		logic [11:0] raw_y_med;
		logic [7:0]  screen_x;
		logic [8:0]  screen_y;
	} touch_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] wdata;
		reading_t              rd;
		touch_t                want;
	} row_t;

	typedef logic [2:0][11:0] triple_t;

	logic clk = 1'b0;
	logic arst_n;

	tmc_in_if #(.SAMPLE_BITS(12)) samples_ch ();
	tmc_out_if #(.SAMPLE_BITS(12), .X_BITS(8), .Y_BITS(9)) result_ch ();
	tmc_cfg_if cfg_ch ();

	touch_median_calibrate_top #(
		.SCREEN_WIDTH(240),
		.SCREEN_HEIGHT(320),
		.SAMPLE_BITS(12)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	logic        cal_en;
	logic        raw_en;
	logic [2:0]  orient;
	logic [11:0] x_lo, x_hi, y_lo, y_hi;

	touch_t touch_q[$];
	int     fails = 0;
	int     burst_left = 0;
	int     idle_cycles = 0;
	logic [7:0] ready_phase = 8'd0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int median3(int p, int q, int r);
		if (p > q)
			return (q > r) ? q : ((p > r) ? r : p);
		return (p > r) ? p : ((q > r) ? r : q);
	endfunction

	function automatic int scale(int v, int lo, int hi, int top);
		int span;
		span = hi - lo;
		if (span == 0)
			return 0;
		return ((v - lo) * top) / span;
	endfunction

	function automatic int sat(int v, int top);
		return (v < 0) ? 0 : ((v > top) ? top : v);
	endfunction

	function automatic touch_t predict_touch(reading_t r);
		int mx, my, mz, a, b, sx, sy;
		touch_t t;
		mx = median3(r.x0, r.x1, r.x2);
		my = median3(r.y0, r.y1, r.y2);
		mz = median3(r.z0, r.z1, r.z2);
		t = '0;
		if (mz < PRESS_MIN || mx < EDGE_LOW || mx > EDGE_HIGH || my < EDGE_LOW || my > EDGE_HIGH)
			return t;
		t.raw_x_med = 12'(mx);
		t.raw_y_med = 12'(my);
		if (cal_en) begin
			a = orient[ORIENT_SWAP] ? my : mx;
			b = orient[ORIENT_SWAP] ? mx : my;
			sx = scale(a, x_lo, x_hi, XTOP);
			sy = scale(b, y_lo, y_hi, YTOP);
			if (orient[ORIENT_INV_X])
				sx = XTOP - sx;
			if (orient[ORIENT_INV_Y])
				sy = YTOP - sy;
		end else if (raw_en) begin
			sx = scale(mx, PROV_LO, PROV_HI, XTOP);
			sy = scale(my, PROV_LO, PROV_HI, YTOP);
		end else begin
			return t;
		end
		t.touch_valid = 1'b1;
		t.screen_x = 8'(sat(sx, XTOP));
		t.screen_y = 9'(sat(sy, YTOP));
		return t;
	endfunction

	function automatic reading_t same(int x, int y, int z);
		return '{12'(x), 12'(y), 12'(z), 12'(x), 12'(y), 12'(z), 12'(x), 12'(y), 12'(z)};
	endfunction

	function automatic touch_t touch_of(bit tv, int rx, int ry, int sx, int sy);
		return '{tv, 12'(rx), 12'(ry), 8'(sx), 9'(sy)};
	endfunction

	function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int d);
		return '{ROW_CFG, idx, 12'(d), '0, '0};
	endfunction

	function automatic row_t predict_row(reading_t rd);
		return '{ROW_PREDICT, '0, '0, rd, '0};
	endfunction

	function automatic row_t typed_row(reading_t rd, touch_t want);
		return '{ROW_TYPED, '0, '0, rd, want};
	endfunction

	function automatic triple_t rand_triple(bit good);
		int base;
		triple_t t;
		if (good) begin
			if ($urandom_range(0, 7) == 0)
				base = $urandom_range(0, 1) ? $urandom_range(78, 82) : $urandom_range(4013, 4017);
			else
				base = $urandom_range(80, 4015);
			for (int j = 0; j < 3; j++)
				t[j] = 12'(base + int'($urandom_range(0, 40)) - 20);
			if ($urandom_range(0, 3) == 0)
				t[$urandom_range(0, 2)] = 12'($urandom);
		end else begin
			for (int j = 0; j < 3; j++)
				t[j] = 12'($urandom);
		end
		return t;
	endfunction

	function automatic reading_t rand_reading();
		bit good;
		triple_t x, y, z;
		good = $urandom_range(0, 4) != 0;
		x = rand_triple(good || $urandom_range(0, 1));
		y = rand_triple(good || $urandom_range(0, 1));
		z = rand_triple(good || $urandom_range(0, 1));
		return '{x[0], y[0], z[0], x[1], y[1], z[1], x[2], y[2], z[2]};
	endfunction

	task automatic pick_span(input int kind, output logic [11:0] lo, output logic [11:0] hi);
		case (span_kind_t'(kind))
			SPAN_RESET: begin
				lo = RST_CAL_MIN;
				hi = RST_CAL_MAX;
			end
			SPAN_FULL: begin
				lo = 12'd0;
				hi = 12'd4095;
			end
			SPAN_REVERSED: begin
				lo = 12'd4095;
				hi = 12'd0;
			end
			SPAN_FLAT: begin
				lo = 12'($urandom);
				hi = lo;
			end
			SPAN_TYPICAL: begin
				lo = 12'($urandom_range(100, 600));
				hi = 12'($urandom_range(3500, 4000));
			end
			default: begin
				lo = 12'($urandom);
				hi = 12'($urandom);
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			REG_CAL_VALID:    cal_en = d[0];
			REG_RAW_MODE:     raw_en = d[0];
			REG_ORIENT_FLAGS: orient = d[2:0];
			REG_CAL_MIN_X:    x_lo = d;
			REG_CAL_MAX_X:    x_hi = d;
			REG_CAL_MIN_Y:    y_lo = d;
			REG_CAL_MAX_Y:    y_hi = d;
			default: ;
		endcase
	endtask

	task automatic push_reading(input reading_t r, input bit typed, input touch_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				samples_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		samples_ch.valid <= 1'b1;
		samples_ch.first_x <= r.x0;
		samples_ch.first_y <= r.y0;
		samples_ch.first_z <= r.z0;
		samples_ch.second_x <= r.x1;
		samples_ch.second_y <= r.y1;
		samples_ch.second_z <= r.z1;
		samples_ch.third_x <= r.x2;
		samples_ch.third_y <= r.y2;
		samples_ch.third_z <= r.z2;
		do @(posedge clk); while (samples_ch.ready !== 1'b1);
		touch_q.push_back(typed ? want : predict_touch(r));
	endtask

	task automatic drain_results();
		samples_ch.valid <= 1'b0;
		while (touch_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		touch_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (touch_q.size() == 0) begin
				$error("result beat with no reading set pending");
				fails++;
			end else begin
				want = touch_q.pop_front();
				check_field("touch_valid", 12'(want.touch_valid), 12'(result_ch.touch_valid));
				check_field("raw_x_med", want.raw_x_med, result_ch.raw_x_med);
				check_field("raw_y_med", want.raw_y_med, result_ch.raw_y_med);
				check_field("screen_x", 12'(want.screen_x), 12'(result_ch.screen_x));
				check_field("screen_y", 12'(want.screen_y), 12'(result_ch.screen_y));
			end
		end
	end

	always @(posedge clk) begin
		ready_phase <= ready_phase + 8'd1;
		case (ready_phase[7:6])
			2'd0: result_ch.ready <= 1'b1;
			2'd1: result_ch.ready <= ready_phase[1:0] != 2'd3;
			2'd2: result_ch.ready <= $urandom_range(0, 2) != 0;
			default: result_ch.ready <= ready_phase[4:0] >= 5'd18;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (samples_ch.valid && samples_ch.ready) ||
				(result_ch.valid === 1'b1 && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		row_t dir_rows[$];
		logic [11:0] wd, lo, hi;

		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.first_x = '0;
		samples_ch.first_y = '0;
		samples_ch.first_z = '0;
		samples_ch.second_x = '0;
		samples_ch.second_y = '0;
		samples_ch.second_z = '0;
		samples_ch.third_x = '0;
		samples_ch.third_y = '0;
		samples_ch.third_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		cal_en = 1'b0;
		raw_en = 1'b1;
		orient = 3'd0;
		x_lo = RST_CAL_MIN;
		x_hi = RST_CAL_MAX;
		y_lo = RST_CAL_MIN;
		y_hi = RST_CAL_MAX;

		dir_rows = '{
			typed_row(same(80, 80, 80), touch_of(1, 80, 80, 0, 0)),
			typed_row(same(4015, 4015, 4015), touch_of(1, 4015, 4015, XTOP, YTOP)),
			typed_row(same(200, 3900, 4095), touch_of(1, 200, 3900, 0, YTOP)),
			typed_row(same(2000, 2000, 79), touch_of(0, 0, 0, 0, 0)),
			typed_row(same(79, 2000, 2000), touch_of(0, 0, 0, 0, 0)),
			typed_row(same(4016, 2000, 2000), touch_of(0, 0, 0, 0, 0)),
			typed_row(same(2000, 79, 2000), touch_of(0, 0, 0, 0, 0)),
			typed_row(same(2000, 4016, 2000), touch_of(0, 0, 0, 0, 0)),
			typed_row(same(0, 0, 0), touch_of(0, 0, 0, 0, 0)),
			typed_row(same(4095, 4095, 4095), touch_of(0, 0, 0, 0, 0)),
			predict_row('{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095,
				12'd1234, 12'd2345, 12'd100}),
			predict_row('{12'hAAA, 12'h555, 12'hFFF, 12'h555, 12'hAAA, 12'h000,
				12'hFFF, 12'h800, 12'h7FF}),
			cfg_row(REG_RAW_MODE, 0),
			typed_row(same(1000, 1000, 1000), touch_of(0, 1000, 1000, 0, 0)),
			cfg_row(REG_UNMAPPED, 12'hFFF),
			cfg_row(REG_CAL_VALID, 12'hFFE),
			typed_row(same(3000, 3000, 3000), touch_of(0, 3000, 3000, 0, 0)),
			cfg_row(REG_CAL_VALID, 1),
			cfg_row(REG_ORIENT_FLAGS, 0),
			cfg_row(REG_CAL_MIN_X, 0),
			cfg_row(REG_CAL_MAX_X, 4095),
			cfg_row(REG_CAL_MIN_Y, 4095),
			cfg_row(REG_CAL_MAX_Y, 0),
			predict_row(same(80, 4015, 500)),
			predict_row(same(4015, 80, 500)),
			predict_row(same(2047, 1000, 4095)),
			cfg_row(REG_ORIENT_FLAGS, 12'hFFF),
			predict_row(same(300, 3800, 900)),
			predict_row('{12'd150, 12'd2500, 12'd90, 12'd160, 12'd2600, 12'd85,
				12'd4000, 12'd10, 12'd3000}),
			cfg_row(REG_CAL_MIN_X, 1000),
			cfg_row(REG_CAL_MAX_X, 1000),
			cfg_row(REG_ORIENT_FLAGS, 2),
			predict_row(same(1000, 2000, 2000)),
			predict_row(same(3500, 600, 2000)),
			cfg_row(REG_ORIENT_FLAGS, 0),
			predict_row(same(1000, 2000, 2000)),
			predict_row(same(90, 3999, 81))
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (i == 0 || dir_rows[i-1].kind != ROW_CFG)
					drain_results();
				write_reg(dir_rows[i].idx, dir_rows[i].wdata);
				if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CFG)
					cfg_ch.valid <= 1'b0;
			end else begin
				push_reading(dir_rows[i].rd, dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			wd = 12'($urandom);
			wd[0] = $urandom_range(0, 3) != 0;
			write_reg(REG_CAL_VALID, wd);
			write_reg(REG_RAW_MODE, 12'($urandom));
			write_reg(REG_ORIENT_FLAGS, 12'($urandom));
			pick_span((p < 3) ? p : $urandom_range(0, 5), lo, hi);
			write_reg(REG_CAL_MIN_X, lo);
			write_reg(REG_CAL_MAX_X, hi);
			pick_span((p < 3) ? p : $urandom_range(0, 5), lo, hi);
			write_reg(REG_CAL_MIN_Y, lo);
			write_reg(REG_CAL_MAX_Y, hi);
			cfg_ch.valid <= 1'b0;
			for (int k = 0; k < PHASE_SETS; k++) begin
				if (p == 3 && k == PHASE_SETS / 2)
					drain_results();
				push_reading(rand_reading(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (2 * LATENCY) @(posedge clk);
		if (fails == 0 && touch_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
